// ===== rtl/idle_wheel_lock_pd_brake_unit_assert.svh =====
// Assertion macros shared by the checker of the idle wheel lock brake unit.
// Plain text macros only; no other dependencies.
`ifndef IDLE_WHEEL_LOCK_PD_BRAKE_UNIT_ASSERT_SVH
`define IDLE_WHEEL_LOCK_PD_BRAKE_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define IWL_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/iwl_pkg.sv =====
// Shared types and constants of the idle wheel lock PD brake unit.
// No dependencies.
`default_nettype none

package iwl_pkg;

    localparam int NUM_WHEELS   = 4;
    localparam int LANE_STAGES  = 6;
    localparam int POS_W        = 32;
    localparam int ERR_W        = POS_W + 1;
    localparam int GAIN_W       = 16;
    localparam int TLIM_W       = 24;
    localparam int ANGLE_W      = 14;
    localparam int PIVOT_W      = 16;
    localparam int CMD_W        = 35;
    localparam int IN_TDATA_W   = 320;
    localparam int OUT_TDATA_W  = 208;
    localparam int ADDR_W       = 5;

    // pi in Q3.13
    localparam logic signed [PIVOT_W-1:0] PI_Q13 = 16'sd25736;
    // wheel command scale factor
    localparam logic signed [10:0] CMD_SCALE = 11'sd1000;

    typedef enum logic [2:0] {
        REG_LOCK_EN    = 3'd0,
        REG_BRAKE_EN   = 3'd1,
        REG_IDLE_LIMIT = 3'd2,
        REG_KP         = 3'd3,
        REG_KD         = 3'd4,
        REG_TLIM       = 3'd5,
        REG_ANGLE      = 3'd6
    } iwl_reg_t;

    // Per-word status that travels beside the lane pipeline.
    typedef struct packed {
        logic locked;
        logic mode;
    } iwl_flags_t;

    // Control from the top level to every lane.
    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
        logic                   enter;
        logic                   capture;
    } iwl_lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/iwl_lane.sv =====
// One wheel lane: captured position, PD torque, clamp, rounding and scale.
// Depends on iwl_pkg.
`default_nettype none

module iwl_lane (
    input  wire logic                                aclk,
    input  wire iwl_pkg::iwl_lane_ctl_t              ctl,
    input  wire logic signed [iwl_pkg::POS_W-1:0]    position,
    input  wire logic signed [iwl_pkg::POS_W-1:0]    velocity,
    input  wire logic [iwl_pkg::GAIN_W-1:0]          kp,
    input  wire logic [iwl_pkg::GAIN_W-1:0]          kd,
    input  wire logic [iwl_pkg::TLIM_W-1:0]          tlim,
    output logic signed [iwl_pkg::CMD_W-1:0]         command
);
    import iwl_pkg::*;

    logic signed [POS_W-1:0]  cap_reg;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [POS_W-1:0]  vel_reg;
    logic signed [49:0]       p_reg, p_next;
    logic signed [48:0]       d_reg, d_next;
    logic signed [50:0]       t_reg, t_next;
    logic signed [50:0]       lim_wide;
    logic signed [50:0]       c_wide;
    logic signed [33:0]       c_reg;
    logic signed [33:0]       rnd_sum;
    logic signed [24:0]       r_reg;
    logic signed [35:0]       prod;
    logic signed [CMD_W-1:0]  m_reg;

    // On the first locked tick the captured value is the current position.
    assign err_next = ctl.enter ? '0
                    : $signed({cap_reg[POS_W-1], cap_reg}) - $signed({position[POS_W-1], position});

    assign p_next = $signed({1'b0, kp}) * err_reg;
    assign d_next = $signed({1'b0, kd}) * vel_reg;
    assign t_next = $signed({p_reg[49], p_reg}) - $signed({{2{d_reg[48]}}, d_reg});

    assign lim_wide = $signed({19'd0, tlim, 8'd0});
    always_comb begin
        if (t_reg > lim_wide) begin
            c_wide = lim_wide;
        end else if (t_reg < -lim_wide) begin
            c_wide = -lim_wide;
        end else begin
            c_wide = t_reg;
        end
    end

    // Round half up, dropping 8 fraction bits; the clamp keeps the result in 25 bits.
    assign rnd_sum = c_reg + 34'sd128;
    assign prod    = r_reg * CMD_SCALE;

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cap_reg <= position;
        end
        if (ctl.load[0]) begin
            err_reg <= err_next;
            vel_reg <= velocity;
        end
        if (ctl.load[1]) begin
            p_reg <= p_next;
            d_reg <= d_next;
        end
        if (ctl.load[2]) begin
            t_reg <= t_next;
        end
        if (ctl.load[3]) begin
            c_reg <= c_wide[33:0];
        end
        if (ctl.load[4]) begin
            r_reg <= rnd_sum[32:8];
        end
        if (ctl.load[5]) begin
            m_reg <= prod[CMD_W-1:0];
        end
    end

    assign command = m_reg;

endmodule

`default_nettype wire

// ===== rtl/iwl_merge.sv =====
// Output stage: merges the lane commands with the lock status and pivot
// angles into one result word held in the output register. Depends on iwl_pkg.
`default_nettype none

module iwl_merge (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         in_valid,
    input  wire iwl_pkg::iwl_flags_t                          flags,
    input  wire logic [iwl_pkg::NUM_WHEELS-1:0][iwl_pkg::CMD_W-1:0] commands,
    input  wire logic [iwl_pkg::ANGLE_W-1:0]                  lock_angle,
    output logic                                              ready,
    output logic                                              m_axis_tvalid,
    input  wire logic                                         m_axis_tready,
    // locked[0], pivot_angle_0..3[64:1], wheel_command_0..3[204:65], zero pad
    output logic [iwl_pkg::OUT_TDATA_W-1:0]                   m_axis_tdata,
    // position_mode[0]
    output logic [0:0]                                        m_axis_tuser
);
    import iwl_pkg::*;

    logic                     valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0]   data_reg, data_next;
    logic                     user_reg;
    logic signed [PIVOT_W-1:0] base;
    logic [PIVOT_W-1:0]       piv [NUM_WHEELS];

    assign ready = ~valid_reg | m_axis_tready;
    assign base  = $signed({2'b00, lock_angle});

    // X pattern: pi - base, base, base - pi, -base.
    assign piv[0] = PI_Q13 - base;
    assign piv[1] = base;
    assign piv[2] = base - PI_Q13;
    assign piv[3] = -base;

    always_comb begin
        data_next = '0;
        data_next[0] = flags.locked;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            if (flags.locked) begin
                data_next[1 + w*PIVOT_W +: PIVOT_W] = piv[w];
            end
            if (flags.mode) begin
                data_next[1 + NUM_WHEELS*PIVOT_W + w*CMD_W +: CMD_W] = commands[w];
            end
        end
    end

    assign valid_next = ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready) begin
            data_reg <= data_next;
            user_reg <= flags.mode;
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = data_reg;
    assign m_axis_tuser[0] = user_reg;

endmodule

`default_nettype wire

// ===== rtl/idle_wheel_lock_pd_brake_unit.sv =====
// Idle wheel lock with PD position brake, four wheel lanes side by side.
// A word passes the six-stage lane pipeline and then the output register.
// Throughput: one word per cycle unless m_axis_tready holds the output back;
// stages fill bubbles under back-pressure.
// Reset (aresetn low, synchronous) unlocks, empties the pipeline and loads the
// register reset values. Depends on iwl_pkg, iwl_lane and iwl_merge.
`default_nettype none

module idle_wheel_lock_pd_brake_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // now_ticks[31:0], last_command_ticks[63:32], position_0..3[191:64],
    // velocity_0..3[319:192]
    input  wire logic [iwl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // locked[0], pivot_angle_0..3[64:1], wheel_command_0..3[204:65], zero pad
    output logic [iwl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // position_mode[0]
    output logic [0:0]                             m_axis_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [iwl_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import iwl_pkg::*;

    logic                 lock_en_reg;
    logic                 brake_en_reg;
    logic [31:0]          idle_limit_reg;
    logic [GAIN_W-1:0]    kp_reg;
    logic [GAIN_W-1:0]    kd_reg;
    logic [TLIM_W-1:0]    tlim_reg;
    logic [ANGLE_W-1:0]   angle_reg;
    iwl_reg_t             reg_sel;
    logic                 cfg_wr;

    logic                 lock_active_reg;
    logic [31:0]          elapsed;
    logic                 idle;
    logic                 accept;

    logic [LANE_STAGES-1:0] valid_reg, valid_next;
    logic [LANE_STAGES-1:0] rdy;
    logic                   out_ready;
    iwl_flags_t             flg_reg [LANE_STAGES];
    iwl_flags_t             flg_in;
    iwl_lane_ctl_t          lane_ctl;
    logic [NUM_WHEELS-1:0][CMD_W-1:0] commands;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = iwl_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_en_reg    <= 1'b0;
            brake_en_reg   <= 1'b0;
            idle_limit_reg <= 32'd1000;
            kp_reg         <= '0;
            kd_reg         <= '0;
            tlim_reg       <= '0;
            angle_reg      <= 14'd6434;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_LOCK_EN:    lock_en_reg    <= pwdata[0];
                REG_BRAKE_EN:   brake_en_reg   <= pwdata[0];
                REG_IDLE_LIMIT: idle_limit_reg <= pwdata;
                REG_KP:         kp_reg         <= pwdata[GAIN_W-1:0];
                REG_KD:         kd_reg         <= pwdata[GAIN_W-1:0];
                REG_TLIM:       tlim_reg       <= pwdata[TLIM_W-1:0];
                REG_ANGLE:      angle_reg      <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LOCK_EN:    prdata = {31'd0, lock_en_reg};
            REG_BRAKE_EN:   prdata = {31'd0, brake_en_reg};
            REG_IDLE_LIMIT: prdata = idle_limit_reg;
            REG_KP:         prdata = {16'd0, kp_reg};
            REG_KD:         prdata = {16'd0, kd_reg};
            REG_TLIM:       prdata = {8'd0, tlim_reg};
            REG_ANGLE:      prdata = {18'd0, angle_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- lock decision at acceptance ----------------
    assign elapsed = s_axis_tdata[31:0] - s_axis_tdata[63:32];
    assign idle    = lock_en_reg & (elapsed > idle_limit_reg);
    assign accept  = s_axis_tvalid & s_axis_tready;

    assign flg_in.locked = idle;
    assign flg_in.mode   = idle & brake_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_active_reg <= 1'b0;
        end else if (accept) begin
            lock_active_reg <= idle;
        end
    end

    // ---------------- pipeline flow ----------------
    // A stage loads when it is empty or its contents move on.
    always_comb begin
        rdy[LANE_STAGES-1] = ~valid_reg[LANE_STAGES-1] | out_ready;
        for (int k = LANE_STAGES - 2; k >= 0; k--) begin
            rdy[k] = ~valid_reg[k] | rdy[k+1];
        end
        valid_next[0] = rdy[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < LANE_STAGES; k++) begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign s_axis_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            flg_reg[0] <= flg_in;
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (rdy[k]) begin
                flg_reg[k] <= flg_reg[k-1];
            end
        end
    end

    assign lane_ctl.load    = rdy;
    assign lane_ctl.enter   = ~lock_active_reg;
    assign lane_ctl.capture = accept & idle & ~lock_active_reg;

    // ---------------- wheel lanes ----------------
    for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
        iwl_lane u_lane (
            .aclk     (aclk),
            .ctl      (lane_ctl),
            .position ($signed(s_axis_tdata[64 + w*POS_W +: POS_W])),
            .velocity ($signed(s_axis_tdata[64 + (NUM_WHEELS + w)*POS_W +: POS_W])),
            .kp       (kp_reg),
            .kd       (kd_reg),
            .tlim     (tlim_reg),
            .command  (commands[w])
        );
    end

    iwl_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (valid_reg[LANE_STAGES-1]),
        .flags         (flg_reg[LANE_STAGES-1]),
        .commands      (commands),
        .lock_angle    (angle_reg),
        .ready         (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/iwl_checker.sv =====
// Port-level checker for the idle wheel lock brake unit, bound to the top level.
// Depends on idle_wheel_lock_pd_brake_unit_assert.svh and iwl_pkg.
`default_nettype none
`include "idle_wheel_lock_pd_brake_unit_assert.svh"

module iwl_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [iwl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [0:0]                        m_axis_tuser
);
    import iwl_pkg::*;

    `IWL_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !m_axis_tvalid,
        "word valid right after reset")

    `IWL_ASSERT_RST(a_mode_needs_lock, aclk, aresetn,
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[0],
        "brake mode without lock")

    `IWL_ASSERT_RST(a_unlocked_zero, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0),
        "unlocked word not all zero")

    `IWL_ASSERT_RST(a_no_brake_zero, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tuser[0])
            |-> (m_axis_tdata[OUT_TDATA_W-1:1 + NUM_WHEELS*PIVOT_W] == '0),
        "wheel command without brake mode")

    `IWL_ASSERT_RST(a_stall_hold, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
        "stalled word changed")

endmodule

bind idle_wheel_lock_pd_brake_unit iwl_checker u_iwl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
